### design/rmq_pkg.sv
// Shared constants for the rotation matrix to quaternion block.
// No dependencies; imported by the top level.
`default_nettype none
package rmq_pkg;

	// Codes for which component comes from the square root.
	localparam logic [1:0] CASE_W = 2'd0;
	localparam logic [1:0] CASE_X = 2'd1;
	localparam logic [1:0] CASE_Y = 2'd2;
	localparam logic [1:0] CASE_Z = 2'd3;

endpackage
`default_nettype wire

### design/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Uses no package items; instantiated by the top level.
`default_nettype none
module rmq_sqrt #(
	parameter int AW = 18,
	parameter int F  = 14
) (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic [AW-1:0]                          arg,
	output logic [((AW+F)+((AW+F)%2))/2-1:0]            root
);
	localparam int NB = (AW + F) + ((AW + F) % 2);
	localparam int RB = NB / 2;

	logic [RB+2:0] rem_s  [1:RB];
	logic [NB-1:0] n_s    [1:RB];
	logic [RB-1:0] root_s [1:RB];

	genvar i;
	generate
		for (i = 0; i < RB; i++) begin : g_stage
			logic [RB+2:0] rem_in;
			logic [NB-1:0] n_in;
			logic [RB-1:0] root_in;
			logic [RB+2:0] cat;
			logic [RB+2:0] trial;
			logic          ge;

			// Stage inputs: the argument scaled to the root format, or the previous stage.
			if (i == 0) begin : g_first
				assign rem_in  = '0;
				assign n_in    = NB'({arg, {F{1'b0}}});
				assign root_in = '0;
			end else begin : g_next
				assign rem_in  = rem_s[i];
				assign n_in    = n_s[i];
				assign root_in = root_s[i];
			end

			// Bring down two bits and try the next root bit.
			assign cat   = {rem_in[RB:0], n_in[NB-1 -: 2]};
			assign trial = {1'b0, root_in, 2'b01};
			assign ge    = (cat >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[i+1] <= {root_in[RB-2:0], ge};
				end
			end

			if (i < RB - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[i+1] <= ge ? (cat - trial) : cat;
						n_s[i+1]   <= {n_in[NB-3:0], 2'b00};
					end
				end
			end
		end
	endgenerate

	assign root = root_s[RB];

endmodule
`default_nettype wire

### design/rmq_div.sv
// Pipelined rounded division of one magnitude by twice the root, one quotient
// bit per stage, with an early overflow flag. No package items used.
`default_nettype none
module rmq_div #(
	parameter int W  = 16,
	parameter int F  = 14,
	parameter int RB = 16
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [W:0]     mag,
	input  wire logic           neg,
	input  wire logic [RB-1:0]  root,
	output logic [W-1:0]        quo,
	output logic                ovf,
	output logic                neg_out
);
	localparam int NW = W + F + 1;
	localparam int XW = (NW > RB + 1 + W) ? NW : (RB + 1 + W);

	logic [XW-1:0] rem_s [0:W-1];
	logic [RB:0]   d_s   [0:W-1];
	logic [W-1:0]  q_s   [0:W];
	logic          ovf_s [0:W];
	logic          neg_s [0:W];

	logic [XW-1:0] num;
	logic [XW-1:0] dtop;

	// Numerator mag * 2^F + root, so the quotient comes out rounded.
	assign num  = XW'({mag, {F{1'b0}}}) + XW'(root);
	assign dtop = XW'({root, 1'b0}) << W;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			d_s[0]   <= {root, 1'b0};
			q_s[0]   <= '0;
			ovf_s[0] <= (num >= dtop);
			neg_s[0] <= neg;
		end
	end

	genvar k;
	generate
		for (k = 0; k < W; k++) begin : g_stage
			logic [XW-1:0] dsh;
			logic          ge;

			// Test quotient bit W-1-k.
			assign dsh = XW'(d_s[k]) << (W - 1 - k);
			assign ge  = (rem_s[k] >= dsh);

			always_ff @(posedge clk) begin
				if (en) begin
					q_s[k+1]   <= {q_s[k][W-2:0], ge};
					ovf_s[k+1] <= ovf_s[k];
					neg_s[k+1] <= neg_s[k];
				end
			end

			if (k < W - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k+1] <= ge ? (rem_s[k] - dsh) : rem_s[k];
						d_s[k+1]   <= d_s[k];
					end
				end
			end
		end
	endgenerate

	assign quo     = q_s[W];
	assign ovf     = ovf_s[W];
	assign neg_out = neg_s[W];

endmodule
`default_nettype wire

### design/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// Usage:
//   The slave channel (s_axis_*) takes one 3x3 matrix per item, nine signed
//   words with FRAC_BITS fraction bits, row 0 column 0 in the lowest bits.
//   The master channel (m_axis_*) gives one quaternion per item: x, y, z, w
//   in tdata from the lowest bits up, and case_taken and bad_matrix in tuser.
//   The pipeline depth is set by the square root pipeline, one root bit per
//   stage, and by the three parallel dividers, one quotient bit per stage.
//   Throughput is one item per clock cycle while the receiver does not stall.
//   Reset clears every valid bit; the pipeline comes up empty and ready.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline holds and s_axis_tready falls in the same cycle; no item
//   is lost or repeated and bubbles inside the pipeline are kept.
`default_nettype none
module rotation_matrix_to_quaternion
	import rmq_pkg::*;
#(
	parameter int WORD_BITS = 16,
	parameter int FRAC_BITS = 14
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
	input  wire logic [((9*WORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// quat_x, quat_y, quat_z, quat_w
	output logic [((4*WORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
	// case_taken (2 bits), bad_matrix
	output logic [2:0]                             m_axis_tuser
);
	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int SW  = W + 1;
	localparam int AW  = W + 2;
	localparam int NB  = (AW + F) + ((AW + F) % 2);
	localparam int RB  = NB / 2;
	localparam int L   = RB + W + 3;
	localparam int AWID = 3 + 3 * SW;
	localparam int BWID = 3 + RB;
	localparam int DB  = W + 1;
	localparam int OUTB = ((4 * W + 7) / 8) * 8;

	logic          en;
	logic [L-1:0]  vld_q;

	// The whole pipeline moves when the output register is free or taken.
	assign en            = !vld_q[L-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: case choice, root argument and the three off-diagonal sums and differences.
	logic signed [W+2:0] a [0:8];
	logic signed [W+2:0] tr;
	logic signed [W+2:0] arg_c;
	logic [1:0]          sel_c;
	logic signed [W+2:0] l0_c, l1_c, l2_c;

	genvar e;
	generate
		for (e = 0; e < 9; e++) begin : g_in
			assign a[e] = (W+3)'(signed'(s_axis_tdata[e*W +: W]));
		end
	endgenerate

	always_comb begin
		tr = a[0] + a[4] + a[8];
		if (tr > 0) begin
			sel_c = CASE_W;
			arg_c = (W+3)'(1 << F) + tr;
			l0_c  = a[7] - a[5];
			l1_c  = a[2] - a[6];
			l2_c  = a[3] - a[1];
		end else if (a[0] >= a[4] && a[0] >= a[8]) begin
			sel_c = CASE_X;
			arg_c = (W+3)'(1 << F) + a[0] - a[4] - a[8];
			l0_c  = a[3] + a[1];
			l1_c  = a[2] + a[6];
			l2_c  = a[7] - a[5];
		end else if (a[4] > a[8]) begin
			sel_c = CASE_Y;
			arg_c = (W+3)'(1 << F) + a[4] - a[0] - a[8];
			l0_c  = a[1] + a[3];
			l1_c  = a[5] + a[7];
			l2_c  = a[2] - a[6];
		end else begin
			sel_c = CASE_Z;
			arg_c = (W+3)'(1 << F) + a[8] - a[0] - a[4];
			l0_c  = a[2] + a[6];
			l1_c  = a[5] + a[7];
			l2_c  = a[3] - a[1];
		end
	end

	logic [AW-1:0]   arg_s1;
	logic [AWID-1:0] side_s1;

	// The bad flag sits above the case code so the pair lands in tuser as is.
	always_ff @(posedge clk) begin
		if (en) begin
			if (arg_c < 1) begin
				arg_s1 <= AW'(1);
			end else begin
				arg_s1 <= arg_c[AW-1:0];
			end
			side_s1 <= {(arg_c < 1), sel_c, l2_c[SW-1:0], l1_c[SW-1:0], l0_c[SW-1:0]};
		end
	end

	// Square root pipeline, with the side data delayed alongside.
	logic [RB-1:0]   root;
	logic [AWID-1:0] side_a_q [1:RB];

	rmq_sqrt #(
		.AW (AW),
		.F  (F)
	) u_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (arg_s1),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_a_q[1] <= side_s1;
			for (int i = 2; i <= RB; i++) begin
				side_a_q[i] <= side_a_q[i-1];
			end
		end
	end

	// Three dividers for the off-diagonal components.
	logic [W-1:0] quo  [0:2];
	logic         ovf  [0:2];
	logic         nego [0:2];

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_lane
			logic signed [SW-1:0] s;
			logic [SW-1:0]        mag;

			assign s   = signed'(side_a_q[RB][g*SW +: SW]);
			assign mag = s[SW-1] ? SW'(-s) : SW'(s);

			rmq_div #(
				.W  (W),
				.F  (F),
				.RB (RB)
			) u_div (
				.clk     (clk),
				.en      (en),
				.mag     (mag),
				.neg     (s[SW-1]),
				.root    (root),
				.quo     (quo[g]),
				.ovf     (ovf[g]),
				.neg_out (nego[g])
			);
		end
	endgenerate

	logic [BWID-1:0] side_b_q [1:DB];

	always_ff @(posedge clk) begin
		if (en) begin
			side_b_q[1] <= {side_a_q[RB][AWID-1 -: 3], root};
			for (int i = 2; i <= DB; i++) begin
				side_b_q[i] <= side_b_q[i-1];
			end
		end
	end

	// Final stage: sign, saturation and placement of the components.
	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] lane_v [0:2];
	logic [RB:0]  diag_full;
	logic [W-1:0] diag_v;
	logic [1:0]   sel_f;
	logic [RB-1:0] root_f;

	assign sel_f     = side_b_q[DB][BWID-2 -: 2];
	assign root_f    = side_b_q[DB][RB-1:0];
	assign diag_full = ({1'b0, root_f} + (RB+1)'(1)) >> 1;
	assign diag_v    = (diag_full > (RB+1)'(POS_MAX)) ? POS_MAX : W'(diag_full);

	generate
		for (g = 0; g < 3; g++) begin : g_sat
			always_comb begin
				if (nego[g]) begin
					if (ovf[g] || quo[g] > NEG_MIN) begin
						lane_v[g] = NEG_MIN;
					end else begin
						lane_v[g] = W'(-quo[g]);
					end
				end else begin
					if (ovf[g] || quo[g] > POS_MAX) begin
						lane_v[g] = POS_MAX;
					end else begin
						lane_v[g] = quo[g];
					end
				end
			end
		end
	endgenerate

	logic [W-1:0] qx, qy, qz, qw;

	always_comb begin
		case (sel_f)
			CASE_W: begin
				qx = lane_v[0]; qy = lane_v[1]; qz = lane_v[2]; qw = diag_v;
			end
			CASE_X: begin
				qx = diag_v; qy = lane_v[0]; qz = lane_v[1]; qw = lane_v[2];
			end
			CASE_Y: begin
				qx = lane_v[0]; qy = diag_v; qz = lane_v[1]; qw = lane_v[2];
			end
			default: begin
				qx = lane_v[0]; qy = lane_v[1]; qz = diag_v; qw = lane_v[2];
			end
		endcase
	end

	logic [OUTB-1:0] tdata_s;
	logic [2:0]      tuser_s;

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_s <= OUTB'({qw, qz, qy, qx});
			tuser_s <= side_b_q[DB][BWID-1 -: 3];
		end
	end

	assign m_axis_tdata = tdata_s;
	assign m_axis_tuser = tuser_s;

endmodule
`default_nettype wire
